// ----- src/stpb_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// stpb_pkg
// Shared types, register map and unorm arithmetic for the sprite tint,
// premultiply and blend unit.
// ============================================================================
package stpb_pkg;

    // Channel format: unsigned normalized, code v means v / CH_MAX.
    localparam int CH_BITS = 8;
    localparam logic [CH_BITS-1:0] CH_MAX  = '1;
    localparam logic [CH_BITS-1:0] CH_HALF = CH_MAX >> 1;

    typedef logic [CH_BITS-1:0] ch_t;

    // One input item: texel (straight alpha) and destination pixel.
    typedef struct packed {
        ch_t tex_red;
        ch_t tex_green;
        ch_t tex_blue;
        ch_t tex_alpha;
        ch_t dst_red;
        ch_t dst_green;
        ch_t dst_blue;
        ch_t dst_alpha;
    } pix_in_t;

    // One result item: blended pixel.
    typedef struct packed {
        ch_t out_red;
        ch_t out_green;
        ch_t out_blue;
        ch_t out_alpha;
    } pix_out_t;

    // Blend mode codes.
    typedef logic [1:0] mode_t;
    localparam mode_t MODE_NORMAL   = 2'd0;
    localparam mode_t MODE_ADDITIVE = 2'd1;
    localparam mode_t MODE_MULTIPLY = 2'd2;
    localparam mode_t MODE_SCREEN   = 2'd3;

    // Register map: register index = byte address / 4.
    localparam int ADDR_BITS = 5;
    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_TINT_RED   = 3'd0;
    localparam reg_idx_t REG_TINT_GREEN = 3'd1;
    localparam reg_idx_t REG_TINT_BLUE  = 3'd2;
    localparam reg_idx_t REG_TINT_ALPHA = 3'd3;
    localparam reg_idx_t REG_OPACITY    = 3'd4;
    localparam reg_idx_t REG_BLEND_MODE = 3'd5;

    // Rounded unorm product (a*b + CH_HALF) / CH_MAX. The division by
    // 2^B - 1 is exact as (x + (x >> B) + 1) >> B for x below 2^(2B) - 1.
    function automatic ch_t unorm_mul(input ch_t a, input ch_t b);
        logic [2*CH_BITS-1:0] x;
        logic [2*CH_BITS:0]   q;
        x = (2*CH_BITS)'(a) * (2*CH_BITS)'(b) + (2*CH_BITS)'(CH_HALF);
        q = (2*CH_BITS+1)'(x) + (2*CH_BITS+1)'(x >> CH_BITS) + (2*CH_BITS+1)'(1);
        return q[2*CH_BITS-1:CH_BITS];
    endfunction

    // Sum that saturates at CH_MAX.
    function automatic ch_t sat_add(input ch_t a, input ch_t b);
        logic [CH_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CH_BITS] ? CH_MAX : s[CH_BITS-1:0];
    endfunction

endpackage

// ----- src/sprite_tint_premultiply_blend.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sprite_tint_premultiply_blend
// Tints a straight-alpha texel, premultiplies it and blends it onto a
// destination pixel by the normal, additive, multiply or screen rule.
// ============================================================================
// Throughput: one item per cycle; busy is always low, the receiver cannot stall.
// The five stages follow the chain of dependent unorm products
// (tex*tint, *opacity, *alpha, blend product, saturating sum), one per stage.
// Reset clears the stage valid bits and loads the register reset values.
module sprite_tint_premultiply_blend (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  stpb_pkg::pix_in_t                    data,
    output logic                                 done,
    output stpb_pkg::pix_out_t                   result,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [stpb_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import stpb_pkg::*;

    localparam int STAGES = 5;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    ch_t   tint_reg [3];
    ch_t   tint_alpha_reg;
    ch_t   opacity_reg;
    mode_t mode_reg;

    logic     cfg_wr;
    reg_idx_t cfg_idx;
    logic     accept;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[ADDR_BITS-1:2];
    assign accept  = start && !busy;

    // Register writes take the low bits of the data word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tint_reg[0]    <= CH_MAX;
            tint_reg[1]    <= CH_MAX;
            tint_reg[2]    <= CH_MAX;
            tint_alpha_reg <= CH_MAX;
            opacity_reg    <= CH_MAX;
            mode_reg       <= MODE_NORMAL;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_TINT_RED:   tint_reg[0]    <= pwdata[CH_BITS-1:0];
                REG_TINT_GREEN: tint_reg[1]    <= pwdata[CH_BITS-1:0];
                REG_TINT_BLUE:  tint_reg[2]    <= pwdata[CH_BITS-1:0];
                REG_TINT_ALPHA: tint_alpha_reg <= pwdata[CH_BITS-1:0];
                REG_OPACITY:    opacity_reg    <= pwdata[CH_BITS-1:0];
                REG_BLEND_MODE: mode_reg       <= pwdata[1:0];
                default:        ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            REG_TINT_RED:   prdata = 32'(tint_reg[0]);
            REG_TINT_GREEN: prdata = 32'(tint_reg[1]);
            REG_TINT_BLUE:  prdata = 32'(tint_reg[2]);
            REG_TINT_ALPHA: prdata = 32'(tint_alpha_reg);
            REG_OPACITY:    prdata = 32'(opacity_reg);
            REG_BLEND_MODE: prdata = 32'(mode_reg);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Valid bits travel alongside the data stages.
    // ------------------------------------------------------------------
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;

    assign valid_next = {valid_reg[STAGES-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Datapath stages. Colors are handled as three independent lanes.
    // ------------------------------------------------------------------
    ch_t tex [3];
    ch_t dst [3];

    assign tex[0] = data.tex_red;
    assign tex[1] = data.tex_green;
    assign tex[2] = data.tex_blue;
    assign dst[0] = data.dst_red;
    assign dst[1] = data.dst_green;
    assign dst[2] = data.dst_blue;

    // Stage 1 outputs: tinted color and tinted alpha.
    ch_t c1_reg [3];
    ch_t d1_reg [3];
    ch_t a1_reg;
    ch_t da1_reg;
    // Stage 2 outputs: effective alpha.
    ch_t c2_reg [3];
    ch_t d2_reg [3];
    ch_t ea2_reg;
    ch_t da2_reg;
    // Stage 3 outputs: premultiplied source and attenuated destination.
    ch_t s3_reg [3];
    ch_t d3_reg [3];
    ch_t dinv3_reg [3];
    ch_t ea3_reg;
    ch_t dainv3_reg;
    // Stage 4 outputs: mode product and final alpha.
    ch_t s4_reg [3];
    ch_t d4_reg [3];
    ch_t dinv4_reg [3];
    ch_t m4_reg [3];
    ch_t alpha4_reg;
    // Stage 5: result register.
    ch_t out5_reg [3];
    ch_t alpha5_reg;

    always_ff @(posedge clk)
    begin
        // Stage 1: tint the texel.
        for (int i = 0; i < 3; i++)
        begin
            c1_reg[i] <= unorm_mul(tex[i], tint_reg[i]);
            d1_reg[i] <= dst[i];
        end
        a1_reg  <= unorm_mul(data.tex_alpha, tint_alpha_reg);
        da1_reg <= data.dst_alpha;

        // Stage 2: apply opacity to get the effective alpha.
        for (int i = 0; i < 3; i++)
        begin
            c2_reg[i] <= c1_reg[i];
            d2_reg[i] <= d1_reg[i];
        end
        ea2_reg <= unorm_mul(a1_reg, opacity_reg);
        da2_reg <= da1_reg;

        // Stage 3: premultiply and attenuate the destination by 1 - alpha.
        for (int i = 0; i < 3; i++)
        begin
            s3_reg[i]    <= unorm_mul(c2_reg[i], ea2_reg);
            d3_reg[i]    <= d2_reg[i];
            dinv3_reg[i] <= unorm_mul(d2_reg[i], CH_MAX - ea2_reg);
        end
        ea3_reg    <= ea2_reg;
        dainv3_reg <= unorm_mul(da2_reg, CH_MAX - ea2_reg);

        // Stage 4: the one product that depends on the source value.
        for (int i = 0; i < 3; i++)
        begin
            s4_reg[i]    <= s3_reg[i];
            d4_reg[i]    <= d3_reg[i];
            dinv4_reg[i] <= dinv3_reg[i];
            if (mode_reg == MODE_MULTIPLY)
            begin
                m4_reg[i] <= unorm_mul(s3_reg[i], d3_reg[i]);
            end
            else
            begin
                m4_reg[i] <= unorm_mul(d3_reg[i], CH_MAX - s3_reg[i]);
            end
        end
        alpha4_reg <= sat_add(ea3_reg, dainv3_reg);

        // Stage 5: saturating combine per blend rule.
        for (int i = 0; i < 3; i++)
        begin
            case (mode_reg)
                MODE_ADDITIVE: out5_reg[i] <= sat_add(s4_reg[i], d4_reg[i]);
                MODE_MULTIPLY: out5_reg[i] <= sat_add(m4_reg[i], dinv4_reg[i]);
                MODE_SCREEN:   out5_reg[i] <= sat_add(s4_reg[i], m4_reg[i]);
                default:       out5_reg[i] <= sat_add(s4_reg[i], dinv4_reg[i]);
            endcase
        end
        alpha5_reg <= alpha4_reg;
    end

    // ------------------------------------------------------------------
    // Result ports
    // ------------------------------------------------------------------
    assign done             = valid_reg[STAGES-1];
    assign result.out_red   = out5_reg[0];
    assign result.out_green = out5_reg[1];
    assign result.out_blue  = out5_reg[2];
    assign result.out_alpha = alpha5_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Every result strobe comes from an accepted item that has passed all the valid stages.
    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, STAGES))
        else $error("result strobe without a matching item");

    // Every accepted item produces a result strobe.
    a_item_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##5 done)
        else $error("accepted item produced no result");

    // A write to the blend mode register lands in the mode register.
    a_mode_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && cfg_idx == REG_BLEND_MODE) |=> mode_reg == $past(pwdata[1:0]))
        else $error("blend mode write lost");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the sprite tint, premultiply and blend unit.
// A directed pass covers channel extremes under every blend mode. Random
// phases then reprogram the tint, opacity and mode registers and stream
// pixels with varying sender gaps. Each blended pixel is checked against
// an in-bench prediction, and the register file is checked by readback.
// ============================================================================
module tb_top;
    import stpb_pkg::*;

    localparam int unsigned UNIT = (1 << CH_BITS) - 1;
    localparam int PHASES = 14;
    localparam int PIXELS_PER_PHASE = 100;
    localparam int DRAIN_CYCLES = 12;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    pix_in_t data = '0;
    logic done;
    pix_out_t result;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // Register image kept by the bench, starting from the reset values.
    ch_t cfg_red = CH_MAX;
    ch_t cfg_green = CH_MAX;
    ch_t cfg_blue = CH_MAX;
    ch_t cfg_alpha = CH_MAX;
    ch_t cfg_opacity = CH_MAX;
    mode_t cfg_mode = MODE_NORMAL;

    pix_in_t pixels_to_send[$];
    pix_out_t blended_due[$];
    int idle_pct = 0;
    bit hold_send = 1'b0;
    bit took = 1'b0;
    int errors = 0;

    sprite_tint_premultiply_blend u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .data    (data),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Rounded product of two unorm codes.
    function automatic int unsigned unorm_product(input int unsigned a, input int unsigned b);
        return (a * b + UNIT / 2) / UNIT;
    endfunction

    function automatic int unsigned sat_sum(input int unsigned a, input int unsigned b);
        return (a + b > UNIT) ? UNIT : a + b;
    endfunction

    // One color channel under the current blend mode; keep is 1 - source alpha.
    function automatic ch_t mix_channel(input int unsigned s, input int unsigned d,
                                        input int unsigned keep);
        case (cfg_mode)
            MODE_ADDITIVE: return ch_t'(sat_sum(s, d));
            MODE_MULTIPLY: return ch_t'(sat_sum(unorm_product(s, d), unorm_product(d, keep)));
            MODE_SCREEN:   return ch_t'(sat_sum(s, unorm_product(d, UNIT - s)));
            default:       return ch_t'(sat_sum(s, unorm_product(d, keep)));
        endcase
    endfunction

    // Expected blended pixel for one texel and destination pair.
    function automatic pix_out_t blend_pixel(input pix_in_t px);
        int unsigned ea;
        int unsigned keep;
        pix_out_t o;
        ea = unorm_product(unorm_product(px.tex_alpha, cfg_alpha), cfg_opacity);
        keep = UNIT - ea;
        o.out_red = mix_channel(unorm_product(unorm_product(px.tex_red, cfg_red), ea),
                                px.dst_red, keep);
        o.out_green = mix_channel(unorm_product(unorm_product(px.tex_green, cfg_green), ea),
                                  px.dst_green, keep);
        o.out_blue = mix_channel(unorm_product(unorm_product(px.tex_blue, cfg_blue), ea),
                                 px.dst_blue, keep);
        o.out_alpha = ch_t'(sat_sum(ea, unorm_product(px.dst_alpha, keep)));
        return o;
    endfunction

    // Channel value that favors the two ends of the range.
    function automatic ch_t pick_channel();
        case ($urandom_range(7))
            0: return '0;
            1: return CH_MAX;
            default: return ch_t'($urandom);
        endcase
    endfunction

    // Register write; the bench image follows the write edge.
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_TINT_RED:   cfg_red = value[CH_BITS-1:0];
            REG_TINT_GREEN: cfg_green = value[CH_BITS-1:0];
            REG_TINT_BLUE:  cfg_blue = value[CH_BITS-1:0];
            REG_TINT_ALPHA: cfg_alpha = value[CH_BITS-1:0];
            REG_OPACITY:    cfg_opacity = value[CH_BITS-1:0];
            REG_BLEND_MODE: cfg_mode = value[1:0];
            default: ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Read back every defined register and compare with the image.
    task automatic check_regs();
        logic [31:0] want;
        for (int k = 0; k <= int'(REG_BLEND_MODE); k++)
        begin
            case (reg_idx_t'(k))
                REG_TINT_RED:   want = cfg_red;
                REG_TINT_GREEN: want = cfg_green;
                REG_TINT_BLUE:  want = cfg_blue;
                REG_TINT_ALPHA: want = cfg_alpha;
                REG_OPACITY:    want = cfg_opacity;
                default:        want = cfg_mode;
            endcase
            @(negedge clk);
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b0;
            paddr <= {reg_idx_t'(k), 2'b00};
            @(negedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            if (prdata !== want)
                report_mismatch($sformatf("readback of register %0d", k), prdata, want);
            @(negedge clk);
            psel <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    // Program all registers with junk in the unused upper bits, poke the
    // unmapped addresses, then confirm the register file by readback.
    task automatic program_config(input ch_t r, input ch_t g, input ch_t b, input ch_t a,
                                  input ch_t op, input mode_t m);
        write_reg(REG_TINT_RED, ($urandom & ~32'(UNIT)) | r);
        write_reg(REG_TINT_GREEN, ($urandom & ~32'(UNIT)) | g);
        write_reg(REG_TINT_BLUE, ($urandom & ~32'(UNIT)) | b);
        write_reg(REG_TINT_ALPHA, ($urandom & ~32'(UNIT)) | a);
        write_reg(REG_OPACITY, ($urandom & ~32'(UNIT)) | op);
        write_reg(REG_BLEND_MODE, ($urandom & ~32'h3) | m);
        for (int k = int'(REG_BLEND_MODE) + 1; k < 8; k++)
            write_reg(reg_idx_t'(k), $urandom);
        check_regs();
    endtask

    // Wait until every queued pixel is accepted and every result is back.
    task automatic wait_drained();
        do @(posedge clk);
        while (pixels_to_send.size() != 0 || start || blended_due.size() != 0);
    endtask

    // Acceptance and result checking at the rising edge.
    always @(posedge clk)
    begin
        took = rst_n && start && !busy;
        if (took)
            blended_due.push_back(blend_pixel(data));
        if (rst_n && done)
        begin
            if (blended_due.size() == 0)
                report_mismatch("result with no pixel outstanding", result, 0);
            else
            begin
                pix_out_t want;
                static string names [4] = '{"out_red", "out_green", "out_blue", "out_alpha"};
                want = blended_due.pop_front();
                for (int f = 0; f < 4; f++)
                    if (result[31-8*f -: 8] !== want[31-8*f -: 8])
                        report_mismatch(names[f], result[31-8*f -: 8], want[31-8*f -: 8]);
            end
        end
    end

    // Pixel driver: a held item stays on the port until it is accepted.
    always @(negedge clk)
    begin
        if (!start || took)
        begin
            if (rst_n && !hold_send && pixels_to_send.size() != 0
                && $urandom_range(99) >= idle_pct)
            begin
                start <= 1'b1;
                data <= pixels_to_send.pop_front();
            end
            else
                start <= 1'b0;
        end
    end

    // Stimulus sequence.
    initial
    begin
        pix_in_t corner [6];
        pix_in_t px;
        corner[0] = '0;
        corner[1] = '1;
        corner[2] = '{8'd255, 8'd255, 8'd255, 8'd0, 8'd10, 8'd20, 8'd30, 8'd40};
        corner[3] = '{8'd200, 8'd100, 8'd50, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0};
        corner[4] = '{8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128};
        corner[5] = '{8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset values, then the corner pixels under each blend mode.
        check_regs();
        for (int m = 0; m < 4; m++)
        begin
            if (m != 0)
                program_config(CH_MAX, CH_MAX, CH_MAX, CH_MAX, CH_MAX, mode_t'(m));
            foreach (corner[i])
                pixels_to_send.push_back(corner[i]);
            wait_drained();
        end

        // Random phases; the first two pin the tint and opacity registers at an extreme.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 0)
                program_config(CH_MAX, CH_MAX, CH_MAX, CH_MAX, CH_MAX, mode_t'(ph % 4));
            else if (ph == 1)
                program_config('0, '0, '0, '0, '0, mode_t'(ph % 4));
            else
                program_config(pick_channel(), pick_channel(), pick_channel(),
                               pick_channel(), pick_channel(), mode_t'(ph % 4));
            idle_pct = (ph < 5) ? 12 : (ph < 10) ? 71 : 0;
            for (int n = 0; n < PIXELS_PER_PHASE; n++)
            begin
                px = '{pick_channel(), pick_channel(), pick_channel(), pick_channel(),
                       pick_channel(), pick_channel(), pick_channel(), pick_channel()};
                pixels_to_send.push_back(px);
                // Halfway through some phases, stop sending until the pipe is empty.
                if ((ph == 3 || ph == 9) && n == PIXELS_PER_PHASE / 2)
                begin
                    while (pixels_to_send.size() != 0) @(posedge clk);
                    hold_send = 1'b1;
                    do @(posedge clk); while (start || blended_due.size() != 0);
                    hold_send = 1'b0;
                end
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
